// File: rtl/core/qsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsv_pkg
// Widths, command and status codes and saturation helpers shared by the
// state-vector gate engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

	localparam int MAX_QUBITS = 10;
	localparam int AMP_WIDTH  = 16;
	localparam int FRAC_BITS  = 14;
	localparam int COEF_W     = 16;
	localparam int CFG_W      = 4;
	localparam int AW         = MAX_QUBITS;
	localparam int VEC_SIZE   = 1 << AW;
	localparam int QN_W       = $clog2(MAX_QUBITS + 1);
	localparam int COEF_DEPTH = 16;

	localparam int PROD_W     = COEF_W + AMP_WIDTH;
	localparam int TERM_W     = PROD_W + 2;
	localparam int RND_W      = TERM_W - FRAC_BITS;
	localparam int ACC_W      = RND_W + 2;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	localparam int SQ_W       = 2 * AMP_WIDTH;
	localparam int NORM_W     = 2 * AMP_WIDTH + MAX_QUBITS;
	localparam int ROOT_W     = (NORM_W + 1) / 2;
	localparam int SQRT_W     = 2 * ROOT_W;
	localparam int DIVD_W     = AMP_WIDTH + FRAC_BITS;
	localparam int EXT_W      = ((AMP_WIDTH > 16) ? AMP_WIDTH : 16) + 1;
	localparam int DRAW_W     = 16;
	localparam int DRAW_SH    = 12;
	localparam int CMP_W      = (NORM_W > DRAW_W + DRAW_SH) ? NORM_W : DRAW_W + DRAW_SH;

	localparam int IN_W       = 80;
	localparam int OUT_W      = 40;

	localparam logic [2:0] FN_SET_COEF = 3'd0;
	localparam logic [2:0] FN_GATE1    = 3'd1;
	localparam logic [2:0] FN_GATE2    = 3'd2;
	localparam logic [2:0] FN_MEASURE  = 3'd3;
	localparam logic [2:0] FN_WRITE    = 3'd4;
	localparam logic [2:0] FN_READ     = 3'd5;
	localparam logic [2:0] FN_RESET    = 3'd6;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_RANGE     = 2'd1;
	localparam logic [1:0] STAT_EQUAL     = 2'd2;
	localparam logic [1:0] STAT_ZERO_NORM = 2'd3;

	typedef logic signed [AMP_WIDTH-1:0] amp_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		amp_t im;
		amp_t re;
	} amp_pair_t;

	function automatic amp_t sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-AMP_WIDTH:0] top;
		top = v[ACC_W-1:AMP_WIDTH-1];
		if (top == '0 || top == '1)
			return v[AMP_WIDTH-1:0];
		return v[ACC_W-1] ? {1'b1, {(AMP_WIDTH-1){1'b0}}} : {1'b0, {(AMP_WIDTH-1){1'b1}}};
	endfunction

	function automatic amp_t sat_ext_to_amp(input logic signed [EXT_W-1:0] v);
		logic [EXT_W-AMP_WIDTH:0] top;
		top = v[EXT_W-1:AMP_WIDTH-1];
		if (top == '0 || top == '1)
			return v[AMP_WIDTH-1:0];
		return v[EXT_W-1] ? {1'b1, {(AMP_WIDTH-1){1'b0}}} : {1'b0, {(AMP_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic [15:0] sat_ext_to_16(input logic signed [EXT_W-1:0] v);
		logic [EXT_W-16:0] top;
		top = v[EXT_W-1:15];
		if (top == '0 || top == '1)
			return v[15:0];
		return v[EXT_W-1] ? 16'h8000 : 16'h7fff;
	endfunction

	function automatic amp_t sat_scale(input logic [DIVD_W-1:0] q, input logic neg);
		logic [DIVD_W:0] s;
		logic [DIVD_W-AMP_WIDTH+1:0] top;
		s = neg ? -{1'b0, q} : {1'b0, q};
		top = s[DIVD_W:AMP_WIDTH-1];
		if (top == '0 || top == '1)
			return s[AMP_WIDTH-1:0];
		return s[DIVD_W] ? {1'b1, {(AMP_WIDTH-1){1'b0}}} : {1'b0, {(AMP_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic [AW-1:0] insert_zero(input logic [AW-1:0] j, input logic [3:0] pos);
		logic [AW-1:0] low;
		low = ~({AW{1'b1}} << pos);
		return ((j & ~low) << 1) | (j & low);
	endfunction

	localparam amp_t AMP_ONE = sat_ext_to_amp(EXT_W'(16384));

endpackage

// File: rtl/core/qsv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsv_div
// Restoring divider, one quotient bit per cycle, for the renormalising scale.
// ----------------------------------------------------------------------------
module qsv_div
	import qsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	localparam int CW = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] d_q;
	logic [DIVD_W-1:0] quo_q;
	logic [ROOT_W:0]   trial;
	logic [ROOT_W:0]   diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(DIVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				d_q    <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/qsv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsv_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module qsv_sqrt
	import qsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NORM_W-1:0] value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q;
	logic              done_q;
	logic [SQRT_W-1:0] v_q;
	logic [SQRT_W-1:0] res_q;
	logic [SQRT_W-1:0] bit_q;
	logic [SQRT_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			v_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= !start && busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
				v_q    <= SQRT_W'(value);
				res_q  <= '0;
				bit_q  <= SQRT_W'(1) << (SQRT_W - 2);
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0])
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

// File: rtl/core/qubit_state_vector_gate_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine
// One-qubit gates run pair by pair and two-qubit gates quad by quad, paced by the
// single amplitude RAM port and the shared complex multiply-accumulate.
// Measure runs the divider once per kept entry and skips it at zero norm.
// One command in flight; the next beat is taken while a result waits.
// After reset a clearing sweep over all 2^10 entries runs before the first beat.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine
	import qsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CFG_W-1:0]  cfg_wdata,  // active_qubits
	input  logic              s_tvalid,
	output logic              s_tready,
	// func, qubit_a, qubit_b, amp_index, coef_index, value_re, value_im, random_draw
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// read_re, read_im, outcome, status
	output logic [OUT_W-1:0]  m_tdata
);

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_RDC  = 5'd2;
	localparam logic [4:0] ST_GRD  = 5'd3;
	localparam logic [4:0] ST_GCAP = 5'd4;
	localparam logic [4:0] ST_GMUL = 5'd5;
	localparam logic [4:0] ST_GACC = 5'd6;
	localparam logic [4:0] ST_GWR  = 5'd7;
	localparam logic [4:0] ST_MRD  = 5'd8;
	localparam logic [4:0] ST_MSQ  = 5'd9;
	localparam logic [4:0] ST_MACC = 5'd10;
	localparam logic [4:0] ST_MDEC = 5'd11;
	localparam logic [4:0] ST_SQRT = 5'd12;
	localparam logic [4:0] ST_NRD  = 5'd13;
	localparam logic [4:0] ST_NCAP = 5'd14;
	localparam logic [4:0] ST_NDIV = 5'd15;
	localparam logic [4:0] ST_NWR  = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	logic [2:0]         in_func;
	logic [3:0]         in_qa;
	logic [3:0]         in_qb;
	logic [AW-1:0]      in_ai;
	logic [3:0]         in_ci;
	logic signed [15:0] in_vre;
	logic signed [15:0] in_vim;
	logic [DRAW_W-1:0]  in_draw;
	logic               in_acc;

	assign in_func = s_tdata[2:0];
	assign in_qa   = s_tdata[6:3];
	assign in_qb   = s_tdata[10:7];
	assign in_ai   = s_tdata[20:11];
	assign in_ci   = s_tdata[24:21];
	assign in_vre  = s_tdata[40:25];
	assign in_vim  = s_tdata[56:41];
	assign in_draw = s_tdata[72:57];

	logic [4:0]        state_q;
	logic [CFG_W-1:0]  active_q;
	logic [QN_W-1:0]   n_eff;
	logic [AW-1:0]     lenm1;
	logic [3:0]        lo_q;
	logic [3:0]        hi_q;
	logic              four_q;
	logic [DRAW_W-1:0] draw_q;
	logic [AW-1:0]     blk_q;
	logic [1:0]        k_q;
	logic [1:0]        r_q;
	logic [1:0]        c_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     clr_q;
	logic              clr_res_q;
	amp_t              v_re_q [4];
	amp_t              v_im_q [4];
	coef_t             coef_re_q [COEF_DEPTH];
	coef_t             coef_im_q [COEF_DEPTH];
	logic signed [PROD_W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic [SQ_W-1:0]   sq_s1;
	logic [NORM_W-1:0] p0_q, p1_q;
	logic              outcome_q;
	logic              znorm_q;
	logic [ROOT_W-1:0] s_q;
	amp_pair_t         a_q;
	logic              lose_q;
	logic [15:0]       res_re_q, res_im_q;
	logic [1:0]        status_q;
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;

	amp_pair_t         mem [VEC_SIZE];
	amp_pair_t         rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	amp_pair_t         mem_wdata;

	logic [AW-1:0]     blk_base;
	logic [AW-1:0]     lo_bit, hi_bit;
	logic [1:0]        sel;
	logic [AW-1:0]     gidx;
	logic [1:0]        size_last;
	logic              blk_last;
	logic [3:0]        cidx;
	logic signed [TERM_W-1:0] t_re, t_im;
	logic signed [RND_W-1:0]  rnd_re, rnd_im;
	amp_t              rd_re, rd_im;
	logic [SQ_W-1:0]   sq_rr, sq_ii;
	logic              mbit;
	logic              lose_c;
	logic [CMP_W-1:0]  draw_x;
	logic              outcome_c;
	logic [NORM_W-1:0] tot;
	logic [AMP_WIDTH-1:0] mag_re, mag_im;
	logic [DIVD_W-1:0] dvd_re, dvd_im;
	logic              div_start, div_done_re, div_done_im;
	logic [DIVD_W-1:0] quo_re, quo_im;
	logic              sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;
	amp_pair_t         scaled;

	always_comb begin
		if (active_q == '0)
			n_eff = QN_W'(1);
		else if (active_q > MAX_QUBITS)
			n_eff = QN_W'(MAX_QUBITS);
		else
			n_eff = QN_W'(active_q);
		lenm1 = ~({AW{1'b1}} << n_eff);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		lo_bit    = AW'(1) << lo_q;
		hi_bit    = AW'(1) << hi_q;
		blk_base  = four_q ? insert_zero(insert_zero(blk_q, lo_q), hi_q)
		                   : insert_zero(blk_q, lo_q);
		sel       = (state_q == ST_GWR) ? r_q : k_q;
		gidx      = blk_base | (sel[0] ? lo_bit : '0) | (sel[1] ? hi_bit : '0);
		size_last = four_q ? 2'd3 : 2'd1;
		blk_last  = blk_q == (four_q ? (lenm1 >> 2) : (lenm1 >> 1));
		cidx      = four_q ? {r_q, c_q} : {2'b00, r_q[0], c_q[0]};
	end

	always_comb begin
		t_re   = TERM_W'(p_rr_s1) - TERM_W'(p_ii_s1) + TERM_W'(ROUND_HALF);
		t_im   = TERM_W'(p_ri_s1) + TERM_W'(p_ir_s1) + TERM_W'(ROUND_HALF);
		rnd_re = RND_W'(t_re >>> FRAC_BITS);
		rnd_im = RND_W'(t_im >>> FRAC_BITS);
	end

	always_comb begin
		rd_re     = rd_q.re;
		rd_im     = rd_q.im;
		sq_rr     = rd_re * rd_re;
		sq_ii     = rd_im * rd_im;
		mbit      = |(i_q & lo_bit);
		lose_c    = mbit != outcome_q;
		draw_x    = CMP_W'({draw_q, {DRAW_SH{1'b0}}});
		outcome_c = draw_x > CMP_W'(p0_q);
		tot       = outcome_c ? p1_q : p0_q;
		mag_re    = rd_re[AMP_WIDTH-1] ? AMP_WIDTH'(-rd_re) : AMP_WIDTH'(rd_re);
		mag_im    = rd_im[AMP_WIDTH-1] ? AMP_WIDTH'(-rd_im) : AMP_WIDTH'(rd_im);
		dvd_re    = (DIVD_W'(mag_re) << FRAC_BITS) + DIVD_W'(s_q >> 1);
		dvd_im    = (DIVD_W'(mag_im) << FRAC_BITS) + DIVD_W'(s_q >> 1);
		div_start = (state_q == ST_NCAP) && !lose_c && !znorm_q;
		sq_start  = (state_q == ST_MDEC) && (tot != '0);
		scaled.re = sat_scale(quo_re, a_q.re[AMP_WIDTH-1]);
		scaled.im = sat_scale(quo_im, a_q.im[AMP_WIDTH-1]);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = i_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_q == '0)
					mem_wdata.re = AMP_ONE;
			end
			ST_IDLE: begin
				mem_addr     = in_ai;
				mem_we       = in_acc && (in_func == FN_WRITE) && (in_ai <= lenm1);
				mem_wdata.re = sat_ext_to_amp(EXT_W'(in_vre));
				mem_wdata.im = sat_ext_to_amp(EXT_W'(in_vim));
			end
			ST_GRD: begin
				mem_addr = gidx;
			end
			ST_GWR: begin
				mem_we       = 1'b1;
				mem_addr     = gidx;
				mem_wdata.re = sat_acc(acc_re_q);
				mem_wdata.im = sat_acc(acc_im_q);
			end
			ST_NWR: begin
				mem_we = 1'b1;
				if (!lose_q)
					mem_wdata = znorm_q ? a_q : scaled;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_q <= mem[mem_addr];
	end

	qsv_div u_div_re (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_re),
		.divisor  (s_q),
		.done     (div_done_re),
		.quotient (quo_re)
	);

	qsv_div u_div_im (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_im),
		.divisor  (s_q),
		.done     (div_done_im),
		.quotient (quo_im)
	);

	qsv_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (tot),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(10);
		end else if (cfg_wen) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < COEF_DEPTH; e++) begin
				coef_re_q[e] <= '0;
				coef_im_q[e] <= '0;
			end
		end else if (in_acc && in_func == FN_SET_COEF) begin
			coef_re_q[in_ci] <= in_vre;
			coef_im_q[in_ci] <= in_vim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			clr_res_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			four_q    <= 1'b0;
			draw_q    <= '0;
			blk_q     <= '0;
			k_q       <= '0;
			r_q       <= '0;
			c_q       <= '0;
			i_q       <= '0;
			for (int e = 0; e < 4; e++) begin
				v_re_q[e] <= '0;
				v_im_q[e] <= '0;
			end
			p_rr_s1   <= '0;
			p_ii_s1   <= '0;
			p_ri_s1   <= '0;
			p_ir_s1   <= '0;
			acc_re_q  <= '0;
			acc_im_q  <= '0;
			sq_s1     <= '0;
			p0_q      <= '0;
			p1_q      <= '0;
			outcome_q <= 1'b0;
			znorm_q   <= 1'b0;
			s_q       <= '0;
			a_q       <= '0;
			lose_q    <= 1'b0;
			res_re_q  <= '0;
			res_im_q  <= '0;
			status_q  <= STAT_OK;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}})
						state_q <= clr_res_q ? ST_DONE : ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						res_re_q  <= '0;
						res_im_q  <= '0;
						outcome_q <= 1'b0;
						znorm_q   <= 1'b0;
						four_q    <= in_func == FN_GATE2;
						if (in_func == FN_GATE2 && in_qb < in_qa) begin
							lo_q <= in_qb;
							hi_q <= in_qa;
						end else begin
							lo_q <= in_qa;
							hi_q <= in_qb;
						end
						draw_q   <= in_draw;
						blk_q    <= '0;
						k_q      <= '0;
						r_q      <= '0;
						c_q      <= '0;
						i_q      <= '0;
						acc_re_q <= '0;
						acc_im_q <= '0;
						p0_q     <= '0;
						p1_q     <= '0;
						unique case (in_func) inside
							FN_GATE1, FN_MEASURE: begin
								if (in_qa >= n_eff) begin
									status_q <= STAT_RANGE;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STAT_OK;
									state_q  <= (in_func == FN_GATE1) ? ST_GRD : ST_MRD;
								end
							end
							FN_GATE2: begin
								if (in_qa >= n_eff || in_qb >= n_eff) begin
									status_q <= STAT_RANGE;
									state_q  <= ST_DONE;
								end else if (in_qa == in_qb) begin
									status_q <= STAT_EQUAL;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STAT_OK;
									state_q  <= ST_GRD;
								end
							end
							FN_WRITE: begin
								status_q <= (in_ai > lenm1) ? STAT_RANGE : STAT_OK;
								state_q  <= ST_DONE;
							end
							FN_READ: begin
								if (in_ai > lenm1) begin
									status_q <= STAT_RANGE;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STAT_OK;
									state_q  <= ST_RDC;
								end
							end
							FN_RESET: begin
								status_q  <= STAT_OK;
								clr_q     <= '0;
								clr_res_q <= 1'b1;
								state_q   <= ST_CLR;
							end
							default: begin
								status_q <= STAT_OK;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_RDC: begin
					res_re_q <= sat_ext_to_16(EXT_W'(rd_re));
					res_im_q <= sat_ext_to_16(EXT_W'(rd_im));
					state_q  <= ST_DONE;
				end
				ST_GRD: begin
					state_q <= ST_GCAP;
				end
				ST_GCAP: begin
					v_re_q[k_q] <= rd_re;
					v_im_q[k_q] <= rd_im;
					if (k_q == size_last) begin
						r_q     <= '0;
						c_q     <= '0;
						state_q <= ST_GMUL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_GRD;
					end
				end
				ST_GMUL: begin
					p_rr_s1 <= coef_re_q[cidx] * v_re_q[c_q];
					p_ii_s1 <= coef_im_q[cidx] * v_im_q[c_q];
					p_ri_s1 <= coef_re_q[cidx] * v_im_q[c_q];
					p_ir_s1 <= coef_im_q[cidx] * v_re_q[c_q];
					state_q <= ST_GACC;
				end
				ST_GACC: begin
					acc_re_q <= acc_re_q + ACC_W'(rnd_re);
					acc_im_q <= acc_im_q + ACC_W'(rnd_im);
					if (c_q == size_last) begin
						state_q <= ST_GWR;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= ST_GMUL;
					end
				end
				ST_GWR: begin
					acc_re_q <= '0;
					acc_im_q <= '0;
					c_q      <= '0;
					if (r_q == size_last) begin
						if (blk_last) begin
							state_q <= ST_DONE;
						end else begin
							blk_q   <= blk_q + 1'b1;
							k_q     <= '0;
							state_q <= ST_GRD;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_GMUL;
					end
				end
				ST_MRD: begin
					state_q <= ST_MSQ;
				end
				ST_MSQ: begin
					sq_s1   <= sq_rr + sq_ii;
					state_q <= ST_MACC;
				end
				ST_MACC: begin
					if (mbit)
						p1_q <= p1_q + NORM_W'(sq_s1);
					else
						p0_q <= p0_q + NORM_W'(sq_s1);
					if (i_q == lenm1) begin
						state_q <= ST_MDEC;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_MRD;
					end
				end
				ST_MDEC: begin
					outcome_q <= outcome_c;
					i_q       <= '0;
					if (tot == '0) begin
						znorm_q  <= 1'b1;
						status_q <= STAT_ZERO_NORM;
						state_q  <= ST_NRD;
					end else begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						s_q     <= sq_root;
						state_q <= ST_NRD;
					end
				end
				ST_NRD: begin
					state_q <= ST_NCAP;
				end
				ST_NCAP: begin
					a_q     <= rd_q;
					lose_q  <= lose_c;
					state_q <= div_start ? ST_NDIV : ST_NWR;
				end
				ST_NDIV: begin
					if (div_done_re && div_done_im)
						state_q <= ST_NWR;
				end
				ST_NWR: begin
					if (i_q == lenm1) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_NRD;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {5'b00000, status_q, outcome_q, res_im_q, res_re_q};
						clr_res_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	a_gate_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GWR) |-> (mem_addr <= lenm1))
		else $error("gate write outside active vector");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_re |-> (state_q == ST_NDIV && div_done_im))
		else $error("divider finished outside scale wait");
	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_SQRT))
		else $error("root finished outside root wait");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result beat raised outside completion");
`endif

endmodule

// File: dv/tb_qubit_state_vector_gate_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qubit_state_vector_gate_engine
// Self-checking bench for the state-vector gate engine: a queue-fed command
// driver, a result monitor and a behavioural state-vector predictor, run
// over several qubit counts, with random stalls on both stream sides in most phases.
// ----------------------------------------------------------------------------
module tb_qubit_state_vector_gate_engine;
	import qsv_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [2:0]  func;
		logic [3:0]  qa;
		logic [3:0]  qb;
		logic [9:0]  ai;
		logic [3:0]  ci;
		logic signed [15:0] vre;
		logic signed [15:0] vim;
		logic [15:0] draw;
	} cmd_t;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic        outcome;
		logic [1:0]  status;
	} res_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	cmd_t cmd_in_flight;
	longint sv_re[VEC_SIZE];
	longint sv_im[VEC_SIZE];
	longint cf_re[16];
	longint cf_im[16];
	int unsigned model_qubits;
	int idle_mode;
	int mismatches;
	int cycles;

	qubit_state_vector_gate_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint sat_part(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint round_term(longint v);
		return (v + ROUND_HALF) >>> FRAC_BITS;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bit_w;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v -= root + bit_w;
				root = (root >> 1) + bit_w;
			end else begin
				root >>= 1;
			end
			bit_w >>= 2;
		end
		return root;
	endfunction

	function automatic longint scale_amp(longint a, longint unsigned s);
		longint unsigned mag, q;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		q = ((mag << FRAC_BITS) + s / 2) / s;
		return sat_part((a < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint unsigned amp_power(int unsigned i);
		return longint'(sv_re[i] * sv_re[i]) + longint'(sv_im[i] * sv_im[i]);
	endfunction

	function automatic void mix_block(int unsigned idx[4], int unsigned sz);
		longint vr[4], vi[4], sr, si, cr, ci;
		for (int c = 0; c < sz; c++) begin
			vr[c] = sv_re[idx[c]];
			vi[c] = sv_im[idx[c]];
		end
		for (int r = 0; r < sz; r++) begin
			sr = 0;
			si = 0;
			for (int c = 0; c < sz; c++) begin
				cr = cf_re[r * sz + c];
				ci = cf_im[r * sz + c];
				sr += round_term(cr * vr[c] - ci * vi[c]);
				si += round_term(cr * vi[c] + ci * vr[c]);
			end
			sv_re[idx[r]] = sat_part(sr);
			sv_im[idx[r]] = sat_part(si);
		end
	endfunction

	function automatic void clear_state();
		for (int i = 0; i < VEC_SIZE; i++) begin
			sv_re[i] = 0;
			sv_im[i] = 0;
		end
		sv_re[0] = 16384;
	endfunction

	function automatic res_t evolve_state(cmd_t c);
		res_t r;
		int unsigned n, len, lo, hi, mask;
		int unsigned idx[4];
		longint unsigned p0, total, s;
		logic outc;
		r = '{default: '0};
		n = (model_qubits == 0) ? 1 :
			(model_qubits > MAX_QUBITS ? MAX_QUBITS : model_qubits);
		len = 1 << n;
		case (c.func)
			FN_SET_COEF: begin
				cf_re[c.ci] = c.vre;
				cf_im[c.ci] = c.vim;
			end
			FN_GATE1: begin
				if (c.qa >= n) begin
					r.status = STAT_RANGE;
				end else begin
					for (int unsigned i = 0; i < len; i++)
						if (!(i & (1 << c.qa))) begin
							idx[0] = i;
							idx[1] = i | (1 << c.qa);
							mix_block(idx, 2);
						end
				end
			end
			FN_GATE2: begin
				if (c.qa >= n || c.qb >= n) begin
					r.status = STAT_RANGE;
				end else if (c.qa == c.qb) begin
					r.status = STAT_EQUAL;
				end else begin
					lo = (c.qa < c.qb) ? c.qa : c.qb;
					hi = (c.qa < c.qb) ? c.qb : c.qa;
					for (int unsigned i = 0; i < len; i++)
						if (!(i & (1 << lo)) && !(i & (1 << hi))) begin
							idx[0] = i;
							idx[1] = i | (1 << lo);
							idx[2] = i | (1 << hi);
							idx[3] = i | (1 << lo) | (1 << hi);
							mix_block(idx, 4);
						end
				end
			end
			FN_MEASURE: begin
				if (c.qa >= n) begin
					r.status = STAT_RANGE;
				end else begin
					mask = 1 << c.qa;
					p0 = 0;
					total = 0;
					for (int unsigned i = 0; i < len; i++)
						if (!(i & mask)) p0 += amp_power(i);
					outc = ((longint'(c.draw) << DRAW_SH) > p0);
					r.outcome = outc;
					for (int unsigned i = 0; i < len; i++)
						if (((i & mask) == 0) == outc) begin
							sv_re[i] = 0;
							sv_im[i] = 0;
						end
					for (int unsigned i = 0; i < len; i++) total += amp_power(i);
					if (total == 0) begin
						r.status = STAT_ZERO_NORM;
					end else begin
						s = int_sqrt(total);
						for (int unsigned i = 0; i < len; i++) begin
							sv_re[i] = scale_amp(sv_re[i], s);
							sv_im[i] = scale_amp(sv_im[i], s);
						end
					end
				end
			end
			FN_WRITE: begin
				if (c.ai >= len) begin
					r.status = STAT_RANGE;
				end else begin
					sv_re[c.ai] = c.vre;
					sv_im[c.ai] = c.vim;
				end
			end
			FN_READ: begin
				if (c.ai >= len) begin
					r.status = STAT_RANGE;
				end else begin
					r.re = sv_re[c.ai];
					r.im = sv_im[c.ai];
				end
			end
			FN_RESET: clear_state();
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [IN_W-1:0] pack_cmd(cmd_t c);
		return IN_W'({c.draw, c.vim, c.vre, c.ci, c.ai, c.qb, c.qa, c.func});
	endfunction

	function automatic int sender_idle_pct();
		return (idle_mode == 0) ? 27 : (idle_mode == 1) ? 77 : 0;
	endfunction

	function automatic int receiver_idle_pct();
		return (idle_mode == 0) ? 77 : (idle_mode == 1) ? 27 : 0;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(evolve_state(cmd_in_flight));
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (pending_cmds.size() != 0 &&
				$urandom_range(99) >= sender_idle_pct()) begin
				cmd_in_flight = pending_cmds.pop_front();
				s_tdata  <= pack_cmd(cmd_in_flight);
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat %h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[15:0] !== want.re || m_tdata[31:16] !== want.im ||
						m_tdata[32] !== want.outcome || m_tdata[34:33] !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
								want.re, want.im, want.outcome, want.status,
								$signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
								m_tdata[32], m_tdata[34:33]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic add_cmd(logic [2:0] func, logic [3:0] qa, logic [3:0] qb,
		logic [9:0] ai, logic [3:0] ci, logic [15:0] vre, logic [15:0] vim,
		logic [15:0] draw);
		cmd_t c;
		c.func = func; c.qa = qa; c.qb = qb; c.ai = ai;
		c.ci = ci; c.vre = vre; c.vim = vim; c.draw = draw;
		pending_cmds.push_back(c);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_qubits(int unsigned v);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		model_qubits = v;
	endtask

	task automatic add_random(int unsigned n);
		int unsigned pick, len;
		logic [3:0] qa, qb;
		logic [9:0] ai;
		logic [15:0] vre, vim;
		logic [2:0] func;
		pick = $urandom_range(99);
		len = 1 << n;
		if (pick < 25) func = FN_SET_COEF;
		else if (pick < 40) func = FN_GATE1;
		else if (pick < 55) func = FN_GATE2;
		else if (pick < 65) func = FN_MEASURE;
		else if (pick < 80) func = FN_WRITE;
		else if (pick < 95) func = FN_READ;
		else if (pick < 98) func = FN_RESET;
		else func = 3'd7;
		qa = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
		qb = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
		ai = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(len - 1);
		if ($urandom_range(1)) begin
			vre = $urandom_range(65535);
			vim = $urandom_range(65535);
		end else begin
			vre = 16'($signed($urandom_range(32768)) - 16384);
			vim = 16'($signed($urandom_range(32768)) - 16384);
		end
		add_cmd(func, qa, qb, ai, $urandom_range(15), vre, vim, $urandom_range(65535));
	endtask

	initial begin
		int unsigned qubit_plan[8] = '{1, 3, 0, 4, 15, 2, 10, 5};
		int unsigned items_per_phase[8] = '{36, 36, 36, 40, 14, 36, 20, 40};
		int unsigned n;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		idle_mode = 0;
		mismatches = 0;
		cycles = 0;
		model_qubits = 10;
		clear_state();
		for (int i = 0; i < 16; i++) begin
			cf_re[i] = 0;
			cf_im[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_qubits(10);

		add_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 1023, 0, 0, 0, 0);
		add_cmd(FN_SET_COEF, 0, 0, 0, 0, 11585, 0, 0);
		add_cmd(FN_SET_COEF, 0, 0, 0, 1, 11585, 0, 0);
		add_cmd(FN_SET_COEF, 0, 0, 0, 2, 11585, 0, 0);
		add_cmd(FN_SET_COEF, 0, 0, 0, 3, -11585, 0, 0);
		add_cmd(FN_SET_COEF, 0, 0, 0, 15, 16'h7fff, 16'h8000, 0);
		add_cmd(FN_GATE1, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 1, 0, 0, 0, 0);
		add_cmd(FN_GATE1, 15, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_GATE2, 3, 3, 0, 0, 0, 0, 0);
		add_cmd(FN_GATE2, 9, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_GATE2, 0, 12, 0, 0, 0, 0, 0);
		add_cmd(FN_MEASURE, 0, 0, 0, 0, 0, 0, 16'hffff);
		add_cmd(FN_MEASURE, 12, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_WRITE, 0, 0, 1023, 0, 16'h8000, 16'h7fff, 0);
		add_cmd(FN_READ, 0, 0, 1023, 0, 0, 0, 0);
		add_cmd(3'd7, 15, 15, 1023, 15, 16'hffff, 16'hffff, 16'hffff);
		add_cmd(FN_RESET, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_WRITE, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_MEASURE, 1, 0, 0, 0, 0, 0, 16'h0001);
		add_cmd(FN_RESET, 0, 0, 0, 0, 0, 0, 0);
		add_cmd(FN_MEASURE, 9, 0, 0, 0, 0, 0, 0);

		for (int p = 0; p < 8; p++) begin
			set_qubits(qubit_plan[p]);
			idle_mode = (p < 3) ? 0 : (p < 6) ? 1 : 2;
			n = (qubit_plan[p] == 0) ? 1 :
				(qubit_plan[p] > MAX_QUBITS ? MAX_QUBITS : qubit_plan[p]);
			if (n < 10)
				add_cmd(FN_READ, 0, 0, 1023, 0, 0, 0, 0);
			for (int k = 0; k < items_per_phase[p]; k++)
				add_random(n);
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: qubit_state_vector_gate_engine.f
rtl/core/qsv_pkg.sv
rtl/core/qsv_div.sv
rtl/core/qsv_sqrt.sv
rtl/core/qubit_state_vector_gate_engine.sv
dv/tb_qubit_state_vector_gate_engine.sv
